@@ hw/rtl/i2cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// shared types and codes of the i2c master bit engine: beat payloads,
// request codes and the command that passes from front to back
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

    // request codes carried in the func field
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // entries in the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] load_index;
        logic [7:0] load_data;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       nack_seen;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [5:0] rx_index;
        logic       done_res;
    } out_item_t;

    // decoded request kind
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_START = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] load_index;
        logic [7:0] load_data;
        logic       sda_sample;
    } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2c_master_bit_engine_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// i2c master advanced by half-period ticks: loads the transmit store, runs
// start, address, write or read bytes with ack handling, and stop
// ----------------------------------------------------------------------------
//
//  channel   ports                         beat
//  --------  ----------------------------  ------------------------------------
//  request   s_valid  s_ready  s_data      tick, store load or start request
//  result    m_valid  m_ready  m_data      line levels and status, one per request
//  config    cfg_valid cfg_ready cfg_data  index of last byte of a transfer
//
//  one request beat per clock while results are taken; a request passes the
//  command queue register, then the result register, before its result appears
//  the bus state machine settles each request as it is popped; the transmit
//  store has one registered read port that is kept pointed at the next byte
//  reset clears all control state; the transmit store is not
//  cleared and must be loaded before use
//  a stalled result side fills the two-entry command queue, then s_ready drops
//
`default_nettype none

module i2c_master_bit_engine_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request beats
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire i2cmbe_pkg::in_item_t  s_data,
    // result beats
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output i2cmbe_pkg::out_item_t      m_data,
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [5:0]            cfg_data
);
    import i2cmbe_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    // register write always taken at once
    assign cfg_ready = 1'b1;

    // front: decode and queue requests
    i2cmbe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    // back: store, bus sequencing and result register
    i2cmbe_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/i2cmbe_front.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_front
// accepts request beats, decodes func and holds the commands in a short
// queue until the bit engine takes them
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire i2cmbe_pkg::in_item_t s_data,
    output logic                     q_valid,
    input  wire logic                q_pop,
    output i2cmbe_pkg::cmd_t         q_cmd
);
    import i2cmbe_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    cmd_t          cmd_in;
    logic          push;
    logic          pop;

    // request decode
    always_comb begin
        cmd_in.load_index = s_data.load_index;
        cmd_in.load_data  = s_data.load_data;
        cmd_in.sda_sample = s_data.sda_sample;
        case (s_data.func)
            FUNC_TICK:  cmd_in.op = OP_TICK;
            FUNC_LOAD:  cmd_in.op = OP_LOAD;
            FUNC_START: cmd_in.op = OP_START;
            default:    cmd_in.op = OP_NONE;
        endcase
    end

    assign s_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push without pop did not grow the queue");

    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop without push did not shrink the queue");

endmodule

`default_nettype wire

@@ hw/rtl/i2cmbe_back.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_back
// bit engine: transmit store, bus state machine and result register
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_back #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire i2cmbe_pkg::cmd_t     q_cmd,
    input  wire logic                 cfg_valid,
    input  wire logic [5:0]           cfg_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output i2cmbe_pkg::out_item_t     m_data
);
    import i2cmbe_pkg::*;

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_START = 6'b000010,
        PH_ADDR  = 6'b000100,
        PH_WRITE = 6'b001000,
        PH_READ  = 6'b010000,
        PH_STOP  = 6'b100000
    } phase_t;

    logic [7:0]    tx_mem [BUFFER_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic [7:0]    cur_byte;

    phase_t        phase_reg, phase_next;
    logic          clk_reg, clk_next;
    logic [3:0]    bit_pos_reg, bit_pos_next;
    logic [5:0]    byte_pos_reg, byte_pos_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    rx_shift_reg, rx_shift_next;
    logic          dl_reg, dl_next;
    logic          dd_reg, dd_next;
    logic [7:0]    addr_byte_reg, addr_byte_next;
    logic [5:0]    last_idx_reg;

    logic          m_valid_reg;
    out_item_t     out_reg;
    out_item_t     res;

    logic          step;
    logic          we;
    logic [AW-1:0] waddr;
    logic          in_range;
    logic [7:0]    tx_val;
    logic [5:0]    byte_inc;
    logic [AW-1:0] rd_inc;

    assign q_pop    = q_valid && (!m_valid_reg || m_ready);
    assign step     = q_pop;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;
    assign cur_byte = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign waddr    = AW'(q_cmd.load_index);
    assign in_range = (32'(q_cmd.load_index) < 32'(BUFFER_DEPTH));
    assign tx_val   = (phase_reg == PH_ADDR) ? addr_byte_reg : cur_byte;
    assign byte_inc = byte_pos_reg + 6'd1;
    assign rd_inc   = (byte_inc == 6'd0) ? '0 :
                      (rd_idx_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : rd_idx_reg + AW'(1);

    always_comb begin
        phase_next     = phase_reg;
        clk_next       = clk_reg;
        bit_pos_next   = bit_pos_reg;
        byte_pos_next  = byte_pos_reg;
        rd_idx_next    = rd_idx_reg;
        rx_shift_next  = rx_shift_reg;
        dl_next        = dl_reg;
        dd_next        = dd_reg;
        addr_byte_next = addr_byte_reg;
        we             = 1'b0;
        res            = '0;

        if (step) begin
            case (q_cmd.op)
                OP_LOAD: begin
                    we = in_range;
                    if (q_cmd.load_index == 6'd0) begin
                        addr_byte_next = q_cmd.load_data;
                    end
                end
                OP_START: begin
                    if (phase_reg == PH_IDLE) begin
                        phase_next = PH_START;
                    end
                end
                OP_TICK: begin
                    case (phase_reg)
                        PH_START: begin
                            clk_next      = 1'b1;
                            dl_next       = 1'b0;
                            dd_next       = 1'b1;
                            bit_pos_next  = 4'd0;
                            byte_pos_next = 6'd0;
                            rd_idx_next   = '0;
                            phase_next    = PH_ADDR;
                        end
                        PH_ADDR, PH_WRITE: begin
                            clk_next = ~clk_reg;
                            if (clk_reg) begin
                                // scl falls: shift out next bit, release for ack
                                if (bit_pos_reg < 4'd8) begin
                                    dl_next      = tx_val[~bit_pos_reg[2:0]];
                                    dd_next      = 1'b1;
                                    bit_pos_next = bit_pos_reg + 4'd1;
                                end else if (bit_pos_reg == 4'd8) begin
                                    dd_next      = 1'b0;
                                    bit_pos_next = 4'd9;
                                end
                            end else if (bit_pos_reg == 4'd9) begin
                                if (q_cmd.sda_sample) begin
                                    res.nack_seen = 1'b1;
                                    bit_pos_next  = 4'd0;
                                    phase_next    = PH_START;
                                end else if (phase_reg == PH_ADDR) begin
                                    bit_pos_next = 4'd0;
                                    if (addr_byte_reg[0]) begin
                                        phase_next    = PH_READ;
                                        byte_pos_next = 6'd0;
                                        rd_idx_next   = '0;
                                    end else begin
                                        phase_next    = PH_WRITE;
                                        byte_pos_next = 6'd1;
                                        rd_idx_next   = AW'(1);
                                    end
                                end else begin
                                    bit_pos_next = 4'd0;
                                    if (byte_pos_reg >= last_idx_reg) begin
                                        byte_pos_next = 6'd0;
                                        rd_idx_next   = '0;
                                        phase_next    = PH_STOP;
                                    end else begin
                                        byte_pos_next = byte_inc;
                                        rd_idx_next   = rd_inc;
                                    end
                                end
                            end
                        end
                        PH_READ: begin
                            clk_next = ~clk_reg;
                            if (clk_reg) begin
                                if (bit_pos_reg < 4'd8) begin
                                    dd_next = 1'b0;
                                end else if (bit_pos_reg == 4'd8) begin
                                    // byte complete, answer no-ack
                                    res.rx_valid = 1'b1;
                                    res.rx_byte  = rx_shift_reg;
                                    res.rx_index = byte_pos_reg;
                                    dl_next      = 1'b1;
                                    dd_next      = 1'b1;
                                    bit_pos_next = 4'd9;
                                end
                            end else if (bit_pos_reg < 4'd8) begin
                                rx_shift_next[~bit_pos_reg[2:0]] = q_cmd.sda_sample;
                                bit_pos_next = bit_pos_reg + 4'd1;
                            end else if (bit_pos_reg == 4'd9) begin
                                bit_pos_next = 4'd0;
                                if (byte_pos_reg >= last_idx_reg) begin
                                    byte_pos_next = 6'd0;
                                    rd_idx_next   = '0;
                                    phase_next    = PH_STOP;
                                end else begin
                                    byte_pos_next = byte_inc;
                                    rd_idx_next   = rd_inc;
                                end
                            end
                        end
                        PH_STOP: begin
                            clk_next      = 1'b1;
                            dl_next       = 1'b1;
                            dd_next       = 1'b0;
                            bit_pos_next  = 4'd0;
                            byte_pos_next = 6'd0;
                            rd_idx_next   = '0;
                            phase_next    = PH_IDLE;
                            res.done_res  = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        res.scl_level = clk_next;
        res.sda_level = dl_next;
        res.sda_drive = dd_next;
        res.busy_res  = (phase_next != PH_IDLE);
    end

    // transmit store: one write port, one registered read port that always
    // looks at the byte the engine will need next
    always_ff @(posedge aclk) begin
        if (we) begin
            tx_mem[waddr] <= q_cmd.load_data;
        end
        rd_data_reg  <= tx_mem[rd_idx_next];
        fwd_hit_reg  <= we && (waddr == rd_idx_next);
        fwd_data_reg <= q_cmd.load_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            clk_reg       <= 1'b1;
            bit_pos_reg   <= 4'd0;
            byte_pos_reg  <= 6'd0;
            rd_idx_reg    <= '0;
            rx_shift_reg  <= 8'd0;
            dl_reg        <= 1'b1;
            dd_reg        <= 1'b0;
            last_idx_reg  <= 6'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            clk_reg      <= clk_next;
            bit_pos_reg  <= bit_pos_next;
            byte_pos_reg <= byte_pos_next;
            rd_idx_reg   <= rd_idx_next;
            rx_shift_reg <= rx_shift_next;
            dl_reg       <= dl_next;
            dd_reg       <= dd_next;
            if (cfg_valid) begin
                last_idx_reg <= cfg_data;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_byte_reg <= addr_byte_next;
        if (step) begin
            out_reg <= res;
        end
    end

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.done_res) |-> (!out_reg.busy_res && phase_reg == PH_IDLE))
        else $error("done reported while engine still busy");

    a_rx_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.rx_valid) |-> (phase_reg == PH_READ && bit_pos_reg == 4'd9))
        else $error("received byte outside read phase");

    a_nack_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.nack_seen) |-> (phase_reg == PH_START))
        else $error("nack did not schedule a new start");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (bit_pos_reg == 4'd0 && byte_pos_reg == 6'd0 && clk_reg))
        else $error("idle engine holds transfer position");

    a_bit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_pos_reg <= 4'd9)
        else $error("bit position past ack slot");

endmodule

`default_nettype wire

@@ bench/i2cmbe_bus_tracker_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_bus_tracker_pkg
// expected line levels of the i2c master bit engine, worked out beat by
// beat from the requests that the engine accepts, and checked in order
// against the result beats
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_bus_tracker_pkg;

    import i2cmbe_pkg::*;

    // the one func code that the engine ignores
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int STORE_DEPTH = 64;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_START,
        BUS_ADDR,
        BUS_WRITE,
        BUS_READ,
        BUS_STOP
    } bus_phase_t;

    class i2c_bus_tracker;
        logic [7:0] tx_copy [STORE_DEPTH];
        bus_phase_t phase;
        logic       scl_q;
        logic       sda_q;
        logic       sda_oe;
        logic [3:0] bit_pos;
        logic [5:0] byte_pos;
        logic [7:0] rx_shift;
        logic [5:0] last_index;
        out_item_t  pending_lines [$];
        int         mismatches;
        int         beats_seen;

        function new();
            phase      = BUS_IDLE;
            scl_q      = 1'b1;
            sda_q      = 1'b1;
            sda_oe     = 1'b0;
            bit_pos    = '0;
            byte_pos   = '0;
            rx_shift   = '0;
            last_index = '0;
            mismatches = 0;
            beats_seen = 0;
            foreach (tx_copy[i]) tx_copy[i] = '0;
        endfunction

        // low half of a sent byte clock: next data bit, released on the ninth
        function void drive_data_bit(logic [7:0] value);
            if (bit_pos < 8) begin
                sda_q  = value[7 - bit_pos];
                sda_oe = 1'b1;
                bit_pos++;
            end else if (bit_pos == 8) begin
                sda_oe  = 1'b0;
                bit_pos = 4'd9;
            end
        endfunction

        function void next_byte();
            bit_pos = '0;
            if (byte_pos >= last_index) begin
                byte_pos = '0;
                phase    = BUS_STOP;
            end else begin
                byte_pos = byte_pos + 6'd1;
            end
        endfunction

        function void note_request(in_item_t req);
            out_item_t res;
            res = '0;
            case (req.func)
                FUNC_LOAD: begin
                    tx_copy[req.load_index] = req.load_data;
                end
                FUNC_START: begin
                    if (phase == BUS_IDLE) phase = BUS_START;
                end
                FUNC_TICK: begin
                    case (phase)
                        BUS_IDLE: ;
                        BUS_START: begin
                            scl_q    = 1'b1;
                            sda_q    = 1'b0;
                            sda_oe   = 1'b1;
                            bit_pos  = '0;
                            byte_pos = '0;
                            phase    = BUS_ADDR;
                        end
                        BUS_ADDR, BUS_WRITE: begin
                            scl_q = ~scl_q;
                            if (!scl_q) begin
                                drive_data_bit(phase == BUS_ADDR ? tx_copy[0] : tx_copy[byte_pos]);
                            end else if (bit_pos == 9) begin
                                if (req.sda_sample) begin
                                    res.nack_seen = 1'b1;
                                    bit_pos       = '0;
                                    phase         = BUS_START;
                                end else if (phase == BUS_ADDR) begin
                                    bit_pos = '0;
                                    if (tx_copy[0][0]) begin
                                        phase    = BUS_READ;
                                        byte_pos = '0;
                                    end else begin
                                        phase    = BUS_WRITE;
                                        byte_pos = 6'd1;
                                    end
                                end else begin
                                    next_byte();
                                end
                            end
                        end
                        BUS_READ: begin
                            scl_q = ~scl_q;
                            if (!scl_q) begin
                                if (bit_pos < 8) begin
                                    sda_oe = 1'b0;
                                end else if (bit_pos == 8) begin
                                    res.rx_valid = 1'b1;
                                    res.rx_byte  = rx_shift;
                                    res.rx_index = byte_pos;
                                    sda_q        = 1'b1;
                                    sda_oe       = 1'b1;
                                    bit_pos      = 4'd9;
                                end
                            end else if (bit_pos < 8) begin
                                rx_shift[7 - bit_pos] = req.sda_sample;
                                bit_pos++;
                            end else if (bit_pos == 9) begin
                                next_byte();
                            end
                        end
                        default: begin
                            scl_q         = 1'b1;
                            sda_q         = 1'b1;
                            sda_oe        = 1'b0;
                            bit_pos       = '0;
                            byte_pos      = '0;
                            phase         = BUS_IDLE;
                            res.done_res  = 1'b1;
                        end
                    endcase
                end
                default: ;
            endcase
            res.scl_level = scl_q;
            res.sda_level = sda_q;
            res.sda_drive = sda_oe;
            res.busy_res  = (phase != BUS_IDLE);
            pending_lines.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            $display("result beat %0d: %s got %0h expected %0h", beats_seen, what, got, want);
        endtask

        task check_lines(out_item_t got);
            out_item_t want;
            beats_seen++;
            if (pending_lines.size() == 0) begin
                report_mismatch("beat with nothing pending", got, '0);
            end else begin
                want = pending_lines.pop_front();
                if (got.scl_level !== want.scl_level)
                    report_mismatch("scl_level", got.scl_level, want.scl_level);
                if (got.sda_level !== want.sda_level)
                    report_mismatch("sda_level", got.sda_level, want.sda_level);
                if (got.sda_drive !== want.sda_drive)
                    report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.nack_seen !== want.nack_seen)
                    report_mismatch("nack_seen", got.nack_seen, want.nack_seen);
                if (got.rx_valid !== want.rx_valid)
                    report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
                if (got.rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
                if (got.rx_index !== want.rx_index)
                    report_mismatch("rx_index", got.rx_index, want.rx_index);
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", got.done_res, want.done_res);
            end
        endtask
    endclass

endpackage

`default_nettype wire

@@ bench/i2c_master_bit_engine_core_test.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_test
// drives whole i2c transfers (address, write and read bytes, ack and nack,
// stop) through the request channel with random line answers, mixed with
// stray loads, starts and spare codes, under random idling on both sides
// and one long result stall; every result beat is checked in order
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cmbe_pkg::*;
    import i2cmbe_bus_tracker_pkg::*;

    localparam int ITEM_TARGET = 900;
    localparam int HOLD_CYCLES = 200;
    localparam int NACK_PCT    = 12;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data  = '0;

    // idling odds in percent, changed per stimulus stretch
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;
    logic hold_off    = 1'b0;

    i2c_bus_tracker lines = new();

    i2c_master_bit_engine_core #(
        .BUFFER_DEPTH(STORE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side: check accepted beats, then pick ready for the next edge
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) lines.check_lines(m_data);
            m_ready <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // one long result stall while the sender keeps offering beats, so the
    // command queue fills and s_ready drops
    initial begin : long_stall
        wait (items_sent >= 400);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // hard stop in case the engine hangs
    initial begin : watchdog
        #2_000_000;
        $display("i2c_master_bit_engine_core_test failed");
        $finish;
    end

    // offer one request beat, maybe after idle cycles, and note it once taken
    task automatic send_item(input in_item_t req);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        lines.note_request(req);
        items_sent++;
    endtask

    // slave answer for the next tick: ack slots mostly ack, data bits random
    function automatic logic line_answer(input int nack_pct);
        if ((lines.phase == BUS_ADDR || lines.phase == BUS_WRITE) && !lines.scl_q
                && lines.bit_pos == 9)
            return ($urandom_range(99) < nack_pct);
        return 1'($urandom_range(1));
    endfunction

    task automatic send_request(input logic [1:0] func, input logic [5:0] idx,
                                input logic [7:0] data, input logic sda);
        in_item_t req;
        req.func       = func;
        req.load_index = idx;
        req.load_data  = data;
        req.sda_sample = sda;
        send_item(req);
    endtask

    // tick with junk in the fields the tick does not use
    task automatic send_tick(input logic sda);
        send_request(FUNC_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)), sda);
    endtask

    // stray beats of any func code
    task automatic send_noise(input int count);
        repeat (count) begin
            send_request(2'($urandom_range(3)), 6'($urandom_range(63)),
                         8'($urandom_range(255)), line_answer(30));
        end
    endtask

    // stop offering and wait until every noted beat has been checked
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lines.pending_lines.size() != 0) @(posedge aclk);
    endtask

    task automatic write_last_index(input logic [5:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lines.last_index = value;
    endtask

    // tick until the bus is idle again, with a sprinkle of stray beats
    task automatic finish_transfer(input int noise_pct);
        while (lines.phase != BUS_IDLE) begin
            if ($urandom_range(99) < noise_pct) send_noise(1);
            else send_tick(line_answer(NACK_PCT));
        end
    endtask

    // a well-formed transfer: address byte, up to two fresh data bytes, start, then ticks until idle
    task automatic run_transfer(input logic reading, input int noise_pct);
        send_request(FUNC_LOAD, 6'd0, {7'($urandom_range(127)), reading}, 1'($urandom_range(1)));
        repeat ($urandom_range(2)) begin
            send_request(FUNC_LOAD, 6'($urandom_range(63, 1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)));
        end
        send_request(FUNC_START, 6'($urandom_range(63)), 8'($urandom_range(255)),
                     1'($urandom_range(1)));
        finish_transfer(noise_pct);
    endtask

    function automatic logic [5:0] pick_last_index();
        case ($urandom_range(9))
            0:       return 6'd0;
            1:       return 6'($urandom_range(6, 3));
            default: return 6'($urandom_range(2));
        endcase
    endfunction

    initial begin : stimulus
        int per_stretch;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_last_index(6'd0);

        // every slot written up front, so no transfer reads an empty slot
        for (int k = STORE_DEPTH - 1; k >= 0; k--) begin
            send_request(FUNC_LOAD, 6'(k), 8'($urandom_range(255)), 1'($urandom_range(1)));
        end

        // idle engine: ticks and the spare code change nothing
        send_request(FUNC_TICK, 6'h3f, 8'hff, 1'b1);
        send_request(FUNC_TICK, 6'h00, 8'h00, 1'b0);
        send_request(FUNC_SPARE, 6'h3f, 8'hff, 1'b1);
        send_request(FUNC_SPARE, 6'h00, 8'h00, 1'b0);
        // data extremes, read address with all ones
        send_request(FUNC_LOAD, 6'h3f, 8'h00, 1'b0);
        send_request(FUNC_LOAD, 6'h00, 8'hff, 1'b1);
        send_request(FUNC_START, 6'h00, 8'h00, 1'b0);
        // second start while busy is dropped
        send_request(FUNC_START, 6'h3f, 8'hff, 1'b1);
        send_tick(1'b0);
        // load and spare code while busy
        send_request(FUNC_LOAD, 6'h05, 8'h5a, 1'b0);
        send_request(FUNC_SPARE, 6'h12, 8'h34, 1'b1);
        finish_transfer(0);

        // longest write set up, then cut short by a register write mid-transfer
        write_last_index(6'd63);
        send_request(FUNC_LOAD, 6'd0, 8'hfe, 1'b0);
        send_request(FUNC_START, 6'd0, 8'h00, 1'b0);
        repeat (120) send_tick(line_answer(0));
        write_last_index(6'd1);
        finish_transfer(0);

        // single byte read
        write_last_index(6'd0);
        run_transfer(1'b1, 0);

        // random part fills the rest of the item budget in three stretches
        per_stretch = (ITEM_TARGET - items_sent) / 3;

        // random part: sender idles lightly, then receiver, then neither
        for (int stretch = 0; stretch < 3; stretch++) begin
            int target;
            src_idle_pct  = (stretch == 0) ? 7 : (stretch == 1) ? 75 : 0;
            sink_idle_pct = (stretch == 0) ? 75 : (stretch == 1) ? 7 : 0;
            target = items_sent + per_stretch;
            while (items_sent < target) begin
                // no register writes during the long stall, so the queue fills
                if (!hold_off && $urandom_range(3) == 0) write_last_index(pick_last_index());
                // stray bursts can leave a transfer half done; the next
                // transfer then picks it up with its start ignored
                if ($urandom_range(5) == 0) send_noise($urandom_range(8, 1));
                else run_transfer(1'($urandom_range(1)), 8);
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (lines.mismatches == 0 && lines.pending_lines.size() == 0) begin
            $display("i2c_master_bit_engine_core_test passed");
        end else begin
            $display("i2c_master_bit_engine_core_test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
